[hdl/svd_pkg.sv]
package svd_pkg;

  // Fixed field widths of the ports.
  localparam int RAW_W    = 10;
  localparam int THR_W    = 28;
  localparam int SQ_OUT_W = 27;
  localparam int OUT_AXES = 3;

  // Reset value of the variance threshold: limit 7000 over a 128-word window.
  localparam logic [THR_W-1:0] THR_RESET = 28'd896000;

  // Largest value the squared-deviation outputs can show.
  localparam logic [SQ_OUT_W-1:0] SQ_OUT_MAX = {SQ_OUT_W{1'b1}};

  // Depth of the queue between the front and the back.
  localparam int QUEUE_DEPTH = 2;

  // Window fill state around one word, decided by the front.
  typedef struct packed {
    logic filled_before;
    logic filled_after;
  } fill_flags_t;

  // Queue status seen by both sides.
  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  // Back-end sequencer states.
  typedef enum logic [2:0] {
    BS_IDLE,
    BS_READ_OLD,
    BS_UPDATE,
    BS_DIVIDE,
    BS_WALK,
    BS_DRAIN,
    BS_FINISH
  } back_state_t;

endpackage

[hdl/windowed_variance_still_detector.sv]
// Still detector over a sliding window of accelerometer words. Each accepted
// word (accel_x/y/z) is stored in a ring of WINDOW_LEN entries per axis and
// yields one result word: window_full, the sum of squared deviations from the
// truncated window mean per axis (saturated at 2^27-1, zero until the window
// has wrapped), and a still flag that latches once every axis sum falls below
// the threshold written on the cfg port (limit times window length, reset
// 896000). Until the window is full a word passes through the read-old,
// update and finish states; after that the divide state forms the mean by a
// reciprocal multiply and the walk reads the ring through its single read
// port, all axes side by side, before drain and finish. A two-word queue sits
// between the input and the back end, and the result register holds a finished
// word while the next one is worked on. The ring needs no clearing after reset.
module windowed_variance_still_detector #(
  parameter int WINDOW_LEN  = 128,
  parameter int SAMPLE_BITS = 10,
  parameter int AXES        = 3
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         sample_valid,
  output logic                         sample_stall,
  input  logic [svd_pkg::RAW_W-1:0]    accel_x,
  input  logic [svd_pkg::RAW_W-1:0]    accel_y,
  input  logic [svd_pkg::RAW_W-1:0]    accel_z,
  output logic                         result_valid,
  input  logic                         result_stall,
  output logic                         window_full,
  output logic [svd_pkg::SQ_OUT_W-1:0] sq_dev_sum_x,
  output logic [svd_pkg::SQ_OUT_W-1:0] sq_dev_sum_y,
  output logic [svd_pkg::SQ_OUT_W-1:0] sq_dev_sum_z,
  output logic                         still,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [svd_pkg::THR_W-1:0]    cfg_data
);

  localparam int IDX_W   = $clog2(WINDOW_LEN);
  localparam int DATA_W  = AXES * SAMPLE_BITS;
  localparam int ENTRY_W = IDX_W + $bits(svd_pkg::fill_flags_t) + DATA_W;

  logic [svd_pkg::THR_W-1:0] threshold;
  svd_pkg::q_status_t        q_stat;
  logic                      push;
  logic [IDX_W-1:0]          push_idx;
  svd_pkg::fill_flags_t      push_flags;
  logic [DATA_W-1:0]         push_samples;
  logic                      pop;
  logic [ENTRY_W-1:0]        pop_data;

  // Threshold register; writes are always taken.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= svd_pkg::THR_RESET;
    end else if (cfg_valid) begin
      threshold <= cfg_data;
    end
  end

  svd_front #(
    .WINDOW_LEN  (WINDOW_LEN),
    .SAMPLE_BITS (SAMPLE_BITS),
    .AXES        (AXES)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .accel_x      (accel_x),
    .accel_y      (accel_y),
    .accel_z      (accel_z),
    .q_stat       (q_stat),
    .push         (push),
    .push_idx     (push_idx),
    .push_flags   (push_flags),
    .push_samples (push_samples)
  );

  svd_queue #(
    .WIDTH (ENTRY_W)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data ({push_idx, push_flags, push_samples}),
    .pop       (pop),
    .pop_data  (pop_data),
    .stat      (q_stat)
  );

  svd_back #(
    .WINDOW_LEN  (WINDOW_LEN),
    .SAMPLE_BITS (SAMPLE_BITS),
    .AXES        (AXES)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .q_stat       (q_stat),
    .pop          (pop),
    .pop_data     (pop_data),
    .threshold    (threshold),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .window_full  (window_full),
    .sq_dev_sum_x (sq_dev_sum_x),
    .sq_dev_sum_y (sq_dev_sum_y),
    .sq_dev_sum_z (sq_dev_sum_z),
    .still        (still)
  );

endmodule

[hdl/svd_front.sv]
module svd_front #(
  parameter int WINDOW_LEN  = 128,
  parameter int SAMPLE_BITS = 10,
  parameter int AXES        = 3
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          sample_valid,
  output logic                          sample_stall,
  input  logic [svd_pkg::RAW_W-1:0]     accel_x,
  input  logic [svd_pkg::RAW_W-1:0]     accel_y,
  input  logic [svd_pkg::RAW_W-1:0]     accel_z,
  input  svd_pkg::q_status_t            q_stat,
  output logic                          push,
  output logic [$clog2(WINDOW_LEN)-1:0] push_idx,
  output svd_pkg::fill_flags_t          push_flags,
  output logic [AXES*SAMPLE_BITS-1:0]   push_samples
);

  localparam int IDX_W = $clog2(WINDOW_LEN);
  localparam int SB    = SAMPLE_BITS;

  logic [IDX_W-1:0]          write_index;
  logic [IDX_W-1:0]          write_index_next;
  logic                      ring_filled;
  logic                      ring_filled_next;
  logic [IDX_W:0]            idx_inc;
  logic                      wrap;
  logic [svd_pkg::RAW_W-1:0] raw [svd_pkg::OUT_AXES];

  // A word is taken whenever the queue has room.
  assign sample_stall = q_stat.full;
  assign push         = sample_valid && !q_stat.full;

  // The index advances before the store, wrapping at the window length.
  assign idx_inc = {1'b0, write_index} + (IDX_W+1)'(1);
  assign wrap    = (idx_inc >= (IDX_W+1)'(WINDOW_LEN));

  always_comb begin
    write_index_next = wrap ? '0 : idx_inc[IDX_W-1:0];
    ring_filled_next = ring_filled | wrap;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      write_index <= '0;
      ring_filled <= 1'b0;
    end else if (push) begin
      write_index <= write_index_next;
      ring_filled <= ring_filled_next;
    end
  end

  // Classified word handed to the back end.
  assign push_idx                 = write_index_next;
  assign push_flags.filled_before = ring_filled;
  assign push_flags.filled_after  = ring_filled_next;

  assign raw[0] = accel_x;
  assign raw[1] = accel_y;
  assign raw[2] = accel_z;

  // Only the low sample bits of the first axes are kept.
  always_comb begin
    for (int a = 0; a < AXES; a++) begin
      push_samples[a*SB +: SB] = SB'(raw[a]);
    end
  end

endmodule

[hdl/svd_queue.sv]
module svd_queue #(
  parameter int WIDTH = 48
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  logic [WIDTH-1:0]   push_data,
  input  logic               pop,
  output logic [WIDTH-1:0]   pop_data,
  output svd_pkg::q_status_t stat
);

  localparam int DEPTH = svd_pkg::QUEUE_DEPTH;
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [PTR_W:0]   count;

  assign stat.full  = (count == (PTR_W+1)'(DEPTH));
  assign stat.empty = (count == '0);
  assign pop_data   = slots[rd_ptr];

  // Payload slots.
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH-1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH-1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + (PTR_W+1)'(1);
      end else if (pop && !push) begin
        count <= count - (PTR_W+1)'(1);
      end
    end
  end

`ifndef SYNTHESIS
  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    push |-> !stat.full) else $error("queue written while full");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    pop |-> !stat.empty) else $error("queue read while empty");

  a_count_up: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> (count == $past(count) + (PTR_W+1)'(1)))
    else $error("queue count did not follow a lone push");
`endif

endmodule

[hdl/svd_back.sv]
module svd_back #(
  parameter int WINDOW_LEN  = 128,
  parameter int SAMPLE_BITS = 10,
  parameter int AXES        = 3
) (
  input  logic                                                clk,
  input  logic                                                rst,
  input  svd_pkg::q_status_t                                  q_stat,
  output logic                                                pop,
  input  logic [$clog2(WINDOW_LEN)+2+AXES*SAMPLE_BITS-1:0]    pop_data,
  input  logic [svd_pkg::THR_W-1:0]                           threshold,
  output logic                                                result_valid,
  input  logic                                                result_stall,
  output logic                                                window_full,
  output logic [svd_pkg::SQ_OUT_W-1:0]                        sq_dev_sum_x,
  output logic [svd_pkg::SQ_OUT_W-1:0]                        sq_dev_sum_y,
  output logic [svd_pkg::SQ_OUT_W-1:0]                        sq_dev_sum_z,
  output logic                                                still
);

  localparam int IDX_W  = $clog2(WINDOW_LEN);
  localparam int SB     = SAMPLE_BITS;
  localparam int SUM_W  = SB + IDX_W;
  localparam int SQ_W   = 2 * SB;
  localparam int ACC_W  = SQ_W + IDX_W;
  localparam int CMP_W  = (ACC_W > svd_pkg::THR_W) ? ACC_W : svd_pkg::THR_W;
  localparam int DATA_W = AXES * SB;
  localparam int SHIFT  = SUM_W + IDX_W;
  localparam int PROD_W = 2 * SUM_W + 1;

  // Scaled reciprocal of the window length; the product shifted down by SHIFT
  // gives the exact truncated quotient for every sum that fits in SUM_W bits.
  localparam logic [SUM_W:0] RECIP =
    (SUM_W+1)'(((64'd1 << SHIFT) + 64'(WINDOW_LEN) - 64'd1) / 64'(WINDOW_LEN));

  localparam logic [IDX_W-1:0] WALK_LAST = IDX_W'(WINDOW_LEN - 1);

  svd_pkg::back_state_t state;
  svd_pkg::back_state_t state_next;

  // Word being worked on.
  logic [IDX_W-1:0]     e_idx;
  svd_pkg::fill_flags_t e_flags;
  logic [DATA_W-1:0]    e_samp;
  logic [IDX_W-1:0]     cur_idx;
  svd_pkg::fill_flags_t cur_flags;
  logic [DATA_W-1:0]    cur_samp;

  // Sample ring.
  logic [DATA_W-1:0] ring [WINDOW_LEN];
  logic [DATA_W-1:0] rd_data;
  logic [IDX_W-1:0]  rd_addr;
  logic              ring_we;

  // Running sums and the mean.
  logic [SUM_W-1:0]  sums      [AXES];
  logic [SUM_W-1:0]  sums_next [AXES];
  logic [SUM_W-1:0]  div_src   [AXES];
  logic [PROD_W-1:0] prod      [AXES];
  logic [SB-1:0]     quo       [AXES];

  // Window walk pipeline.
  logic [IDX_W-1:0] walk_addr;
  logic             rd_vld;
  logic             sq_vld;
  logic [SB-1:0]    dev    [AXES];
  logic [SQ_W-1:0]  sq     [AXES];
  logic [ACC_W-1:0] acc    [AXES];

  // Decision and output.
  logic                         still_latch;
  logic                         still_latch_next;
  logic                         all_below;
  logic                         out_free;
  logic [svd_pkg::SQ_OUT_W-1:0] sat_val [svd_pkg::OUT_AXES];

  assign {e_idx, e_flags, e_samp} = pop_data;
  assign out_free = !result_valid || !result_stall;

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      svd_pkg::BS_IDLE:     if (!q_stat.empty) state_next = svd_pkg::BS_READ_OLD;
      svd_pkg::BS_READ_OLD: state_next = svd_pkg::BS_UPDATE;
      svd_pkg::BS_UPDATE: begin
        state_next = cur_flags.filled_after ? svd_pkg::BS_DIVIDE : svd_pkg::BS_FINISH;
      end
      svd_pkg::BS_DIVIDE:   state_next = svd_pkg::BS_WALK;
      svd_pkg::BS_WALK:     if (walk_addr == WALK_LAST) state_next = svd_pkg::BS_DRAIN;
      svd_pkg::BS_DRAIN:    if (!rd_vld && !sq_vld) state_next = svd_pkg::BS_FINISH;
      svd_pkg::BS_FINISH:   if (out_free) state_next = svd_pkg::BS_IDLE;
      default:              state_next = svd_pkg::BS_IDLE;
    endcase
  end

  // State outputs.
  always_comb begin
    pop     = 1'b0;
    ring_we = 1'b0;
    rd_addr = walk_addr;
    unique case (state)
      svd_pkg::BS_IDLE:     pop = !q_stat.empty;
      svd_pkg::BS_READ_OLD: rd_addr = cur_idx;
      svd_pkg::BS_UPDATE:   ring_we = 1'b1;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= svd_pkg::BS_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Ring: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (ring_we) begin
      ring[cur_idx] <= cur_samp;
    end
    rd_data <= ring[rd_addr];
  end

  // Sum update, mean product and deviation per axis.
  always_comb begin
    for (int a = 0; a < AXES; a++) begin
      sums_next[a] = sums[a]
                   - (cur_flags.filled_before ? SUM_W'(rd_data[a*SB +: SB]) : '0)
                   + SUM_W'(cur_samp[a*SB +: SB]);
      prod[a]   = PROD_W'(div_src[a]) * PROD_W'(RECIP);
      dev[a]    = (rd_data[a*SB +: SB] >= quo[a]) ? rd_data[a*SB +: SB] - quo[a]
                                                  : quo[a] - rd_data[a*SB +: SB];
    end
  end

  // Running sums are model state and clear at reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int a = 0; a < AXES; a++) begin
        sums[a] <= '0;
      end
    end else if (state == svd_pkg::BS_UPDATE) begin
      sums <= sums_next;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (pop) begin
      cur_idx   <= e_idx;
      cur_flags <= e_flags;
      cur_samp  <= e_samp;
    end
    if (state == svd_pkg::BS_UPDATE) begin
      div_src   <= sums_next;
      walk_addr <= '0;
      for (int a = 0; a < AXES; a++) begin
        acc[a] <= '0;
      end
    end
    if (state == svd_pkg::BS_DIVIDE) begin
      for (int a = 0; a < AXES; a++) begin
        quo[a] <= prod[a][SHIFT +: SB];
      end
    end
    if (state == svd_pkg::BS_WALK) begin
      walk_addr <= walk_addr + IDX_W'(1);
    end
    if (rd_vld) begin
      for (int a = 0; a < AXES; a++) begin
        sq[a] <= SQ_W'(dev[a] * dev[a]);
      end
    end
    if (sq_vld) begin
      for (int a = 0; a < AXES; a++) begin
        acc[a] <= acc[a] + ACC_W'(sq[a]);
      end
    end
  end

  // Walk pipeline tags.
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_vld <= 1'b0;
      sq_vld <= 1'b0;
    end else begin
      rd_vld <= (state == svd_pkg::BS_WALK);
      sq_vld <= rd_vld;
    end
  end

  // Threshold test on the full sums.
  always_comb begin
    all_below = 1'b1;
    for (int a = 0; a < AXES; a++) begin
      if (!(CMP_W'(acc[a]) < CMP_W'(threshold))) all_below = 1'b0;
    end
  end

  assign still_latch_next = still_latch | (cur_flags.filled_after & all_below);

  // Saturate the sums for the output fields; missing axes read as zero.
  for (genvar g = 0; g < svd_pkg::OUT_AXES; g++) begin : g_sat
    if (g < AXES) begin : g_used
      logic [CMP_W-1:0] ext;
      assign ext = CMP_W'(acc[g]);
      assign sat_val[g] = (ext > CMP_W'(svd_pkg::SQ_OUT_MAX)) ? svd_pkg::SQ_OUT_MAX
                                                               : ext[svd_pkg::SQ_OUT_W-1:0];
    end else begin : g_unused
      assign sat_val[g] = '0;
    end
  end

  // Still latch and output word valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      still_latch  <= 1'b0;
      result_valid <= 1'b0;
    end else if (state == svd_pkg::BS_FINISH && out_free) begin
      still_latch  <= still_latch_next;
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  // Output word payload.
  always_ff @(posedge clk) begin
    if (state == svd_pkg::BS_FINISH && out_free) begin
      window_full  <= cur_flags.filled_after;
      sq_dev_sum_x <= sat_val[0];
      sq_dev_sum_y <= sat_val[1];
      sq_dev_sum_z <= sat_val[2];
      still        <= still_latch_next;
    end
  end

`ifndef SYNTHESIS
  a_latch_holds: assert property (@(posedge clk) disable iff (rst)
    still_latch |=> still_latch) else $error("still latch cleared");

  a_empty_window: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !window_full) |->
      (sq_dev_sum_x == '0 && sq_dev_sum_y == '0 && sq_dev_sum_z == '0 && !still))
    else $error("nonzero result before the window filled");

  a_drained: assert property (@(posedge clk) disable iff (rst)
    (state == svd_pkg::BS_FINISH) |-> (!rd_vld && !sq_vld))
    else $error("result formed with the walk pipeline busy");
`endif

endmodule

[dv/testbench.sv]
module testbench;

  localparam int WIN_LEN     = 128;
  localparam int AXIS_CNT    = 3;
  localparam int JITTER_MAX  = 15;
  localparam int CYCLE_LIMIT = 2_000_000;
  localparam int HOLD_CYCLES = 1500;
  localparam int TAIL_CYCLES = 200;
  localparam logic [svd_pkg::RAW_W-1:0] RAW_MAX = {svd_pkg::RAW_W{1'b1}};
  localparam logic [svd_pkg::THR_W-1:0] THR_MAX = {svd_pkg::THR_W{1'b1}};

  typedef logic [svd_pkg::RAW_W-1:0] raw_t;

  typedef struct packed {
    raw_t x;
    raw_t y;
    raw_t z;
  } accel_word_t;

  typedef struct packed {
    logic                         full;
    logic [svd_pkg::SQ_OUT_W-1:0] sq_x;
    logic [svd_pkg::SQ_OUT_W-1:0] sq_y;
    logic [svd_pkg::SQ_OUT_W-1:0] sq_z;
    logic                         still;
  } detector_word_t;

  logic                         clk = 1'b0;
  logic                         rst = 1'b1;
  logic                         sample_valid = 1'b0;
  logic                         sample_stall;
  raw_t                         accel_x = '0;
  raw_t                         accel_y = '0;
  raw_t                         accel_z = '0;
  logic                         result_valid;
  logic                         result_stall = 1'b0;
  logic                         window_full;
  logic [svd_pkg::SQ_OUT_W-1:0] sq_dev_sum_x;
  logic [svd_pkg::SQ_OUT_W-1:0] sq_dev_sum_y;
  logic [svd_pkg::SQ_OUT_W-1:0] sq_dev_sum_z;
  logic                         still;
  logic                         cfg_valid = 1'b0;
  logic                         cfg_ready;
  logic [svd_pkg::THR_W-1:0]    cfg_data = '0;

  // Shared control between the stimulus and the result sink.
  bit          idling_on = 1'b1;
  bit          hold_req = 1'b0;
  int unsigned mismatch_count = 0;
  int unsigned cycle_count = 0;

  // Words the detector still owes, oldest first.
  detector_word_t pending_results[$];

  // Shadow state of the detector.
  raw_t                      win_ring [AXIS_CNT][WIN_LEN];
  int unsigned               axis_total [AXIS_CNT];
  int unsigned               slot;
  bit                        wrapped;
  bit                        still_seen;
  logic [svd_pkg::THR_W-1:0] still_limit;

  windowed_variance_still_detector DUT (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .accel_x      (accel_x),
    .accel_y      (accel_y),
    .accel_z      (accel_z),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .window_full  (window_full),
    .sq_dev_sum_x (sq_dev_sum_x),
    .sq_dev_sum_y (sq_dev_sum_y),
    .sq_dev_sum_z (sq_dev_sum_z),
    .still        (still),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data)
  );

  // Clock with a period of two time units.
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Hard stop in case the detector hangs.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic clear_shadow();
    for (int a = 0; a < AXIS_CNT; a++) begin
      axis_total[a] = 0;
      for (int k = 0; k < WIN_LEN; k++) begin
        win_ring[a][k] = '0;
      end
    end
    slot        = 0;
    wrapped     = 1'b0;
    still_seen  = 1'b0;
    still_limit = svd_pkg::THR_RESET;
  endtask

  // Sum of squared deviations of one axis from its truncated window mean.
  function automatic longint unsigned window_sq_dev(int axis);
    int unsigned       mean;
    longint unsigned   acc;
    longint unsigned   gap;
    mean = axis_total[axis] / WIN_LEN;
    acc  = 0;
    for (int k = 0; k < WIN_LEN; k++) begin
      if (win_ring[axis][k] >= mean) begin
        gap = win_ring[axis][k] - mean;
      end else begin
        gap = mean - win_ring[axis][k];
      end
      acc += gap * gap;
    end
    return acc;
  endfunction

  function automatic logic [svd_pkg::SQ_OUT_W-1:0] clip_sq(longint unsigned s);
    return (s > svd_pkg::SQ_OUT_MAX) ? svd_pkg::SQ_OUT_MAX : s[svd_pkg::SQ_OUT_W-1:0];
  endfunction

  // Advances the shadow window by one word and returns the word it should yield.
  function automatic detector_word_t predict_stillness(accel_word_t w);
    raw_t            v [AXIS_CNT];
    longint unsigned dev [AXIS_CNT];
    bit              all_below;
    detector_word_t  r;
    v[0] = w.x;
    v[1] = w.y;
    v[2] = w.z;
    slot++;
    if (slot >= WIN_LEN) begin
      wrapped = 1'b1;
      slot    = 0;
    end
    for (int a = 0; a < AXIS_CNT; a++) begin
      axis_total[a]     -= win_ring[a][slot];
      win_ring[a][slot]  = v[a];
      axis_total[a]     += v[a];
      dev[a]             = 0;
    end
    all_below = 1'b1;
    if (wrapped) begin
      for (int a = 0; a < AXIS_CNT; a++) begin
        dev[a] = window_sq_dev(a);
        if (!(dev[a] < still_limit)) begin
          all_below = 1'b0;
        end
      end
      if (all_below) begin
        still_seen = 1'b1;
      end
    end
    r.full  = wrapped;
    r.sq_x  = clip_sq(dev[0]);
    r.sq_y  = clip_sq(dev[1]);
    r.sq_z  = clip_sq(dev[2]);
    r.still = still_seen;
    return r;
  endfunction

  function automatic accel_word_t make_word(raw_t x, raw_t y, raw_t z);
    accel_word_t w;
    w.x = x;
    w.y = y;
    w.z = z;
    return w;
  endfunction

  // Mostly uniform values, with the two extremes favored.
  function automatic raw_t noisy_axis();
    unique case ($urandom_range(0, 7))
      0: return '0;
      1: return RAW_MAX;
      default: return raw_t'($urandom_range(0, RAW_MAX));
    endcase
  endfunction

  function automatic raw_t quiet_axis(raw_t base);
    return base + raw_t'($urandom_range(0, JITTER_MAX));
  endfunction

  function automatic raw_t quiet_base();
    return raw_t'($urandom_range(0, RAW_MAX - JITTER_MAX));
  endfunction

  // Offers one word, holding it until the detector takes it.
  task automatic send_sample(accel_word_t w);
    detector_word_t r;
    if (idling_on && $urandom_range(0, 3) == 0) begin
      sample_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    sample_valid <= 1'b1;
    accel_x      <= w.x;
    accel_y      <= w.y;
    accel_z      <= w.z;
    do @(posedge clk); while (sample_stall);
    r = predict_stillness(w);
    pending_results.push_back(r);
  endtask

  task automatic send_noisy(int n);
    repeat (n) send_sample(make_word(noisy_axis(), noisy_axis(), noisy_axis()));
  endtask

  // Stops offering words and waits until every owed word has come back.
  task automatic drain();
    sample_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_limit(logic [svd_pkg::THR_W-1:0] value);
    drain();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid   <= 1'b0;
    still_limit  = value;
  endtask

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatch_count++;
    end
  endtask

  task automatic check_result();
    detector_word_t want;
    if (pending_results.size() == 0) begin
      $error("result word with no expectation pending");
      mismatch_count++;
    end else begin
      want = pending_results.pop_front();
      check_field("window_full", 32'(want.full), 32'(window_full));
      check_field("sq_dev_sum_x", 32'(want.sq_x), 32'(sq_dev_sum_x));
      check_field("sq_dev_sum_y", 32'(want.sq_y), 32'(sq_dev_sum_y));
      check_field("sq_dev_sum_z", 32'(want.sq_z), 32'(sq_dev_sum_z));
      check_field("still", 32'(want.still), 32'(still));
    end
  endtask

  // Every accepted result word is checked against the oldest expectation.
  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) begin
      check_result();
    end
  end

  // Result sink: random stall bursts, plus one long hold-off on request.
  initial begin : result_sink
    int unsigned burst;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        result_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        result_stall <= 1'b0;
        hold_req      = 1'b0;
      end else if (idling_on && $urandom_range(0, 5) == 0) begin
        burst = $urandom_range(1, 12);
        result_stall <= 1'b1;
        repeat (burst) @(posedge clk);
        result_stall <= 1'b0;
      end
    end
  end

  // Field extremes and bit patterns while the window is still filling.
  task automatic test_sample_extremes();
    write_limit('0);
    send_sample(make_word('0, '0, '0));
    send_sample(make_word(RAW_MAX, RAW_MAX, RAW_MAX));
    send_sample(make_word(RAW_MAX, '0, '0));
    send_sample(make_word('0, RAW_MAX, '0));
    send_sample(make_word('0, '0, RAW_MAX));
    send_sample(make_word(10'h2AA, 10'h155, 10'h2AA));
    send_sample(make_word(10'h155, 10'h2AA, 10'h155));
    send_sample(make_word(10'd1, 10'd2, 10'd4));
    send_sample(make_word(10'h200, 10'h100, 10'h080));
    send_sample(make_word(10'h3FE, 10'h3FD, 10'h3FB));
    send_sample(make_word(10'd511, 10'd512, 10'd513));
    send_sample(make_word('0, RAW_MAX, '0));
  endtask

  // Enough words to wrap the window and raise window_full.
  task automatic test_window_wrap();
    send_noisy(120);
  endtask

  // A perfectly flat window gives zero sums, which are not below a zero limit.
  task automatic test_zero_limit();
    accel_word_t flat;
    flat = make_word(noisy_axis(), noisy_axis(), noisy_axis());
    repeat (130) send_sample(flat);
    send_noisy(130);
  endtask

  // Moving windows under several limits that busy data never gets under.
  task automatic test_limit_sweep();
    write_limit(svd_pkg::THR_RESET);
    send_noisy(160);
    write_limit(28'd1);
    send_noisy(160);
    write_limit(28'd5_000_000);
    send_noisy(160);
    write_limit(svd_pkg::THR_W'($urandom_range(2, 6_000_000)));
    send_noisy(160);
  endtask

  // The sink holds off long enough for the detector to back up its input.
  task automatic test_receiver_hold();
    hold_req = 1'b1;
    send_noisy(12);
  endtask

  // Two quiet axes are not enough; the moving one keeps the latch low.
  task automatic test_single_axis_motion();
    raw_t bx;
    raw_t by;
    raw_t bz;
    write_limit(svd_pkg::THR_RESET);
    bx = quiet_base();
    by = quiet_base();
    bz = quiet_base();
    repeat (200) send_sample(make_word(quiet_axis(bx), quiet_axis(by), noisy_axis()));
    repeat (150) send_sample(make_word(noisy_axis(), quiet_axis(by), quiet_axis(bz)));
  endtask

  // A quiet window on every axis sets the still flag.
  task automatic test_quiet_window();
    raw_t bx;
    raw_t by;
    raw_t bz;
    bx = quiet_base();
    by = quiet_base();
    bz = quiet_base();
    repeat (200) send_sample(make_word(quiet_axis(bx), quiet_axis(by), quiet_axis(bz)));
  endtask

  // Largest limit; the flag stays latched through busy data.
  task automatic test_max_limit();
    write_limit(THR_MAX);
    send_noisy(150);
  endtask

  // Back-to-back words with neither side pausing.
  task automatic test_steady_tail();
    idling_on = 1'b0;
    send_noisy(100);
  endtask

  initial begin
    clear_shadow();
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    test_sample_extremes();
    test_window_wrap();
    test_zero_limit();
    test_limit_sweep();
    test_receiver_hold();
    test_single_axis_motion();
    test_quiet_window();
    test_max_limit();
    test_steady_tail();
    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
